// ----- src/rhp_pkg.sv -----
package rhp_pkg;

   // header region tags carried with every byte
   typedef enum logic [2:0] {
      REGION_CODEC   = 3'd0,
      REGION_FLAGS   = 3'd1,
      REGION_SRC_LEN = 3'd2,
      REGION_SRC_ID  = 3'd3,
      REGION_DST_LEN = 3'd4,
      REGION_DST_ID  = 3'd5,
      REGION_PAYLOAD = 3'd6
   } region_type;

   // end-of-frame status codes
   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_SHORT       = 3'd1,
      STATUS_CODEC       = 3'd2,
      STATUS_TRUNC_SRC   = 3'd3,
      STATUS_TRUNC_DLEN  = 3'd4,
      STATUS_TRUNC_DST   = 3'd5,
      STATUS_NO_PAYLOAD  = 3'd6
   } status_type;

   // length field counter values: two bytes to read, low byte next
   localparam logic [15:0] LEN_FIELD_BYTES = 16'd2;
   localparam logic [15:0] LEN_LOW_NEXT    = 16'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      region_type  region;
      logic        frame_end;
      status_type  status;
      logic [7:0]  codec;
      logic [15:0] source_length;
      logic [15:0] dest_length;
   } rsp_type;

   // parser context kept between bytes
   typedef struct packed {
      region_type  region;
      logic [15:0] bytes_left;
      logic [7:0]  length_high;
      logic [7:0]  codec_seen;
      logic [15:0] source_len;
      logic [15:0] dest_len;
   } state_type;

endpackage

// ----- src/rhp_step.sv -----
module rhp_step
   import rhp_pkg::*;
(
   input  state_type  cur_state,
   input  req_type    req,
   input  logic [7:0] max_codec_id,
   output state_type  nxt_state,
   output rsp_type    rsp
);

   status_type  status;
   region_type  tag;
   logic [15:0] len;

   assign len = {cur_state.length_high, req.data_byte};

   // region walk and status for one byte
   always_comb begin
      nxt_state = cur_state;
      status    = STATUS_OK;
      tag       = cur_state.region;
      case (cur_state.region)
         REGION_CODEC: begin
            nxt_state.codec_seen = req.data_byte;
            nxt_state.source_len = '0;
            nxt_state.dest_len   = '0;
            nxt_state.region     = REGION_FLAGS;
            status               = STATUS_SHORT;
         end
         REGION_FLAGS: begin
            nxt_state.region     = REGION_SRC_LEN;
            nxt_state.bytes_left = LEN_FIELD_BYTES;
            status               = STATUS_SHORT;
         end
         REGION_SRC_LEN: begin
            if (cur_state.bytes_left != LEN_LOW_NEXT) begin
               nxt_state.length_high = req.data_byte;
               nxt_state.bytes_left  = LEN_LOW_NEXT;
               status                = STATUS_SHORT;
            end else begin
               nxt_state.source_len = len;
               if (len == '0) begin
                  nxt_state.region     = REGION_DST_LEN;
                  nxt_state.bytes_left = LEN_FIELD_BYTES;
                  status               = STATUS_TRUNC_DLEN;
               end else begin
                  nxt_state.region     = REGION_SRC_ID;
                  nxt_state.bytes_left = len;
                  status               = STATUS_TRUNC_SRC;
               end
            end
         end
         REGION_SRC_ID: begin
            if (cur_state.bytes_left > LEN_LOW_NEXT) begin
               nxt_state.bytes_left = cur_state.bytes_left - 16'd1;
               status               = STATUS_TRUNC_SRC;
            end else begin
               nxt_state.region     = REGION_DST_LEN;
               nxt_state.bytes_left = LEN_FIELD_BYTES;
               status               = STATUS_TRUNC_DLEN;
            end
         end
         REGION_DST_LEN: begin
            if (cur_state.bytes_left != LEN_LOW_NEXT) begin
               nxt_state.length_high = req.data_byte;
               nxt_state.bytes_left  = LEN_LOW_NEXT;
               status                = STATUS_TRUNC_DLEN;
            end else begin
               nxt_state.dest_len = len;
               if (len == '0) begin
                  nxt_state.region     = REGION_PAYLOAD;
                  nxt_state.bytes_left = '0;
                  status               = STATUS_NO_PAYLOAD;
               end else begin
                  nxt_state.region     = REGION_DST_ID;
                  nxt_state.bytes_left = len;
                  status               = STATUS_TRUNC_DST;
               end
            end
         end
         REGION_DST_ID: begin
            if (cur_state.bytes_left > LEN_LOW_NEXT) begin
               nxt_state.bytes_left = cur_state.bytes_left - 16'd1;
               status               = STATUS_TRUNC_DST;
            end else begin
               nxt_state.region     = REGION_PAYLOAD;
               nxt_state.bytes_left = '0;
               status               = STATUS_NO_PAYLOAD;
            end
         end
         default: begin
            // payload, and the unused code treated as payload
            tag              = REGION_PAYLOAD;
            nxt_state.region = REGION_PAYLOAD;
            status           = STATUS_OK;
         end
      endcase

      // frame close: codec check and rearm
      if (req.last_byte) begin
         if (status != STATUS_SHORT && nxt_state.codec_seen > max_codec_id) begin
            status = STATUS_CODEC;
         end
         nxt_state.region      = REGION_CODEC;
         nxt_state.bytes_left  = '0;
         nxt_state.length_high = '0;
      end
   end

   // result fields
   always_comb begin
      rsp.byte_out      = req.data_byte;
      rsp.region        = tag;
      rsp.frame_end     = req.last_byte;
      rsp.status        = req.last_byte ? status : STATUS_OK;
      rsp.codec         = nxt_state.codec_seen;
      rsp.source_length = nxt_state.source_len;
      rsp.dest_length   = nxt_state.dest_len;
   end

endmodule

// ----- src/routing_header_parser.sv -----
// Routing header parser
//
// Request channel (req_valid/req_ready/req_data) takes one frame byte per
// request, with last_byte set on the final byte of a frame. Every request
// yields exactly one response on rsp_valid/rsp_ready/rsp_data: the byte,
// its header region tag, the captured codec and source/destination lengths,
// and on the last byte the frame status.
// csr_write_enable/csr_write_data load max_codec_id; write it only while no
// request is in flight.
//
// A request lands in the input register, then the region logic runs and
// the response register is loaded once the response stage can advance.
// Throughput is one byte per cycle while the receiver keeps up; the only
// loop is the update of the parser context in the response stage.
// When the receiver stalls, the response register holds and the input
// register still takes one more request; req_ready drops only when both
// are full. Reset empties both registers, returns the parser to the codec
// byte region with cleared lengths, and sets max_codec_id to 2.
module routing_header_parser
   import rhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic       in_valid_ff;
   req_type    in_data_ff;
   logic       out_valid_ff;
   rsp_type    out_data_ff;
   state_type  state_ff;
   state_type  state_in;
   rsp_type    rsp_in;
   logic [7:0] max_codec_ff;
   logic       advance;

   // pipeline handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_codec_ff <= 8'd2;
      end else if (csr_write_enable) begin
         max_codec_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   rhp_step u_step (
      .cur_state    (state_ff),
      .req          (in_data_ff),
      .max_codec_id (max_codec_ff),
      .nxt_state    (state_in),
      .rsp          (rsp_in)
   );

   // parser context and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{region: REGION_CODEC, default: '0};
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   // a byte moved to the response stage shows up as a response
   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("response missing after advance");

   // a closing byte rearms the parser
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.last_byte |=>
         state_ff.region == REGION_CODEC && state_ff.bytes_left == '0)
      else $error("parser not rearmed after last byte");

   // status only reported on the closing byte
   a_status_mid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.frame_end |-> out_data_ff.status == STATUS_OK)
      else $error("status set on a non-final byte");

   // back-pressure only when both stages are full and stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request refused with room available");

endmodule

// ----- bench/routing_header_parser_tb.sv -----
`timescale 1ns / 1ps

module routing_header_parser_tb;
   import rhp_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_BYTES   = 330;
   localparam int REPORT_CAP    = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 600;
   localparam int SETTLE_CYCLES = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;

   // bytes waiting to be offered, and responses the parser owes us
   req_type byte_queue[$];
   rsp_type parse_expect[$];

   // shadow copy of the parser context and its codec limit
   region_type  hdr_region   = REGION_CODEC;
   logic [15:0] hdr_left     = 16'd0;
   logic [7:0]  hdr_len_high = 8'd0;
   logic [7:0]  hdr_codec    = 8'd0;
   logic [15:0] hdr_src_len  = 16'd0;
   logic [15:0] hdr_dst_len  = 16'd0;
   logic [7:0]  codec_limit  = 8'd2;

   // handshake flags sampled at each rising edge
   bit req_fired = 1'b0;
   bit rsp_fired = 1'b0;

   int mismatches   = 0;
   int rsp_total    = 0;
   int frame_total  = 0;
   int bytes_queued = 0;
   int cycle_count  = 0;
   int status_seen[8];

   routing_header_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // walk one byte through the header and return the tagged byte
   function automatic rsp_type parse_byte(input req_type r);
      rsp_type     o;
      region_type  here;
      status_type  st;
      logic [15:0] len;
      here = hdr_region;
      st   = STATUS_OK;
      len  = {hdr_len_high, r.data_byte};
      case (hdr_region)
         REGION_CODEC: begin
            hdr_codec   = r.data_byte;
            hdr_src_len = 16'd0;
            hdr_dst_len = 16'd0;
            if (r.last_byte) st = STATUS_SHORT;
            hdr_region = REGION_FLAGS;
         end
         REGION_FLAGS: begin
            if (r.last_byte) st = STATUS_SHORT;
            hdr_region = REGION_SRC_LEN;
            hdr_left   = LEN_FIELD_BYTES;
         end
         REGION_SRC_LEN: begin
            if (hdr_left != LEN_LOW_NEXT) begin
               hdr_len_high = r.data_byte;
               hdr_left     = LEN_LOW_NEXT;
               if (r.last_byte) st = STATUS_SHORT;
            end else begin
               hdr_src_len = len;
               if (len == 16'd0) begin
                  hdr_region = REGION_DST_LEN;
                  hdr_left   = LEN_FIELD_BYTES;
                  if (r.last_byte) st = STATUS_TRUNC_DLEN;
               end else begin
                  hdr_region = REGION_SRC_ID;
                  hdr_left   = len;
                  if (r.last_byte) st = STATUS_TRUNC_SRC;
               end
            end
         end
         REGION_SRC_ID: begin
            if (hdr_left > LEN_LOW_NEXT) begin
               hdr_left = hdr_left - 16'd1;
               if (r.last_byte) st = STATUS_TRUNC_SRC;
            end else begin
               hdr_region = REGION_DST_LEN;
               hdr_left   = LEN_FIELD_BYTES;
               if (r.last_byte) st = STATUS_TRUNC_DLEN;
            end
         end
         REGION_DST_LEN: begin
            if (hdr_left != LEN_LOW_NEXT) begin
               hdr_len_high = r.data_byte;
               hdr_left     = LEN_LOW_NEXT;
               if (r.last_byte) st = STATUS_TRUNC_DLEN;
            end else begin
               hdr_dst_len = len;
               if (len == 16'd0) begin
                  hdr_region = REGION_PAYLOAD;
                  hdr_left   = 16'd0;
                  if (r.last_byte) st = STATUS_NO_PAYLOAD;
               end else begin
                  hdr_region = REGION_DST_ID;
                  hdr_left   = len;
                  if (r.last_byte) st = STATUS_TRUNC_DST;
               end
            end
         end
         REGION_DST_ID: begin
            if (hdr_left > LEN_LOW_NEXT) begin
               hdr_left = hdr_left - 16'd1;
               if (r.last_byte) st = STATUS_TRUNC_DST;
            end else begin
               hdr_region = REGION_PAYLOAD;
               hdr_left   = 16'd0;
               if (r.last_byte) st = STATUS_NO_PAYLOAD;
            end
         end
         // payload, and anything out of range is treated as payload
         default: begin
            here       = REGION_PAYLOAD;
            hdr_region = REGION_PAYLOAD;
            st         = STATUS_OK;
         end
      endcase

      // frame close: codec check unless already short, then rearm
      if (r.last_byte) begin
         if (st != STATUS_SHORT && hdr_codec > codec_limit) st = STATUS_CODEC;
         hdr_region   = REGION_CODEC;
         hdr_left     = 16'd0;
         hdr_len_high = 8'd0;
      end

      o.byte_out      = r.data_byte;
      o.region        = here;
      o.frame_end     = r.last_byte;
      o.status        = r.last_byte ? st : STATUS_OK;
      o.codec         = hdr_codec;
      o.source_length = hdr_src_len;
      o.dest_length   = hdr_dst_len;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // queue a frame; keep trims it to that many bytes, 0 keeps it whole
   task automatic push_frame(input logic [7:0] codec, input logic [15:0] slen,
                             input logic [15:0] dlen, input int pay_len,
                             input int keep);
      req_type r;
      int      src_n;
      int      total;
      src_n = int'(slen);
      total = 6 + src_n + int'(dlen) + pay_len;
      if (keep <= 0 || keep > total) keep = total;
      for (int i = 0; i < keep; i++) begin
         if (i == 0)              r.data_byte = codec;
         else if (i == 2)         r.data_byte = slen[15:8];
         else if (i == 3)         r.data_byte = slen[7:0];
         else if (i == 4 + src_n) r.data_byte = dlen[15:8];
         else if (i == 5 + src_n) r.data_byte = dlen[7:0];
         else                     r.data_byte = 8'($urandom);
         r.last_byte = (i == keep - 1);
         byte_queue = {byte_queue, r};
         bytes_queued++;
      end
   endtask

   // mostly well-formed frames with small ids, some cut short, some noise
   task automatic push_random_frame();
      logic [7:0]  codec;
      logic [15:0] slen;
      logic [15:0] dlen;
      int          pay_len;
      int          keep;
      int          pick;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0) codec = 8'($urandom);
      else codec = codec_limit + 8'($urandom_range(0, 2)) - 8'd1;
      if (pick == 0) begin
         slen    = 16'($urandom);
         dlen    = 16'($urandom);
         pay_len = $urandom_range(0, 8);
         keep    = $urandom_range(1, 10);
      end else begin
         slen    = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         dlen    = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         pay_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         keep    = (pick <= 2) ? $urandom_range(1, 8 + int'(slen) + int'(dlen)) : 0;
      end
      push_frame(codec, slen, dlen, pay_len, keep);
   endtask

   // wait for the pipeline to empty, then let it settle
   task automatic drain();
      while (byte_queue.size() != 0 || req_valid || parse_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_codec_limit(input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      repeat (2) @(negedge clock);
   endtask

   // request driver
   int send_gap    = 0;
   bit send_steady = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fired) begin
            // hold the byte until the parser takes it
         end else if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            req_data  <= byte_queue.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
            send_gap = send_steady ? 0 : $urandom_range(0, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response sink with per-response stalls and one long hold-off
   int recv_stall  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   bit recv_steady = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && rsp_total >= HOLD_AFTER && byte_queue.size() > 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_fired) begin
            if ($urandom_range(0, 63) == 0) recv_steady = !recv_steady;
            recv_stall = recv_steady ? 0 : $urandom_range(0, 16);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_stall != 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predict on each accepted request, check each response
   always @(posedge clock) begin
      rsp_type want;
      req_fired = !reset && req_valid && req_ready;
      rsp_fired = !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (csr_write_enable) codec_limit = csr_write_data;
         if (req_fired) parse_expect = {parse_expect, parse_byte(req_data)};
         if (rsp_fired) begin
            if (parse_expect.size() == 0) begin
               mismatches++;
               $error("response with nothing outstanding: %h", rsp_data);
            end else begin
               want = parse_expect.pop_front();
               check_field("byte_out", want.byte_out, rsp_data.byte_out);
               check_field("region", want.region, rsp_data.region);
               check_field("frame_end", want.frame_end, rsp_data.frame_end);
               check_field("status", want.status, rsp_data.status);
               check_field("codec", want.codec, rsp_data.codec);
               check_field("source_length", want.source_length,
                           rsp_data.source_length);
               check_field("dest_length", want.dest_length, rsp_data.dest_length);
               rsp_total++;
               if (want.frame_end) begin
                  frame_total++;
                  status_seen[want.status]++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL routing_header_parser");
         $finish;
      end
   end

   initial begin
      logic [7:0] limit_plan[5];
      limit_plan[0] = 8'd0;
      limit_plan[1] = 8'd255;
      limit_plan[2] = 8'($urandom);
      limit_plan[3] = 8'($urandom_range(1, 8));
      limit_plan[4] = 8'd2;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames at the reset codec limit
      push_frame(8'hFF, 16'd0, 16'd0, 0, 1);       // one byte, short beats bad codec
      push_frame(8'h00, 16'hFFFF, 16'd0, 0, 3);    // ends on source length high
      push_frame(8'h02, 16'd0, 16'd0, 0, 4);       // zero source length closes frame
      push_frame(8'h01, 16'd1, 16'd0, 0, 5);       // ends on last source id byte
      push_frame(8'h00, 16'd0, 16'd0, 1, 0);       // smallest good frame
      push_frame(8'hFF, 16'd0, 16'd0, 0, 0);       // no payload, codec too large
      drain();

      // random frames under a range of codec limits
      for (int p = 0; p < 5; p++) begin
         write_codec_limit(limit_plan[p]);
         bytes_queued = 0;
         while (bytes_queued < PHASE_BYTES) push_random_frame();
         drain();
      end

      $display("checked %0d bytes in %0d frames, codec limits 2, 0, 255 and random",
               rsp_total, frame_total);
      $display("frame status counts ok..no payload: %0d %0d %0d %0d %0d %0d %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6]);
      if (mismatches == 0 && parse_expect.size() == 0) begin
         $display("PASS routing_header_parser");
      end else begin
         $display("FAIL routing_header_parser");
      end
      $finish;
   end

endmodule
